// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI-mode sector engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_RX    = 2'd1,
    KIND_WDATA = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CMD   = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_WAKE     = 5'd1,
    PH_CMD_SEND = 5'd2,
    PH_CMD_POLL = 5'd3,
    PH_CMD_TAIL = 5'd4,
    PH_RD_TOKEN = 5'd5,
    PH_RD_DATA  = 5'd6,
    PH_RD_TAIL  = 5'd7,
    PH_WR_TOKEN = 5'd8,
    PH_WR_WANT  = 5'd9,
    PH_WR_DATA  = 5'd10,
    PH_WR_CRC   = 5'd11,
    PH_WR_RESP  = 5'd12,
    PH_WR_REJ   = 5'd13,
    PH_WR_BUSY1 = 5'd14,
    PH_WR_GAP   = 5'd15,
    PH_WR_BUSY2 = 5'd16
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_IDLE_TIMEOUT = 3'd1,
    ST_OPCOND_TIME  = 3'd2,
    ST_READ_TIMEOUT = 3'd3,
    ST_WCMD_TIMEOUT = 3'd4,
    ST_WR_REJECTED  = 3'd5
  } status_e;

  localparam int unsigned SectorBytes = 512;
  localparam logic [7:0]  TokenStart  = 8'hFE;

  // classified word passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  operation;
    logic [5:0]  cmd_index;
    logic [31:0] block_address;
    logic [7:0]  rx_byte;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_active;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        want_write_data;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  r1_response;
    logic        high_capacity;
  } result_t;

endpackage

// ===== rtl/sd_spi_command_sector_engine_unit.sv =====
// Path: a word's result passes the input register, then the queue entry, then the
// output register before it is presented.
// Throughput: one word per cycle while the output is not stalled; the sequencer
// retires one queued word each cycle through its single phase register.
// Reset: asynchronous, active low; phase idle, retry_limit 255, queue empty.
// ----------------------------------------------------------------------------
// sd_spi_command_sector_engine_unit
// SD card SPI-mode host sequencer: init, single command, sector read/write.
// ----------------------------------------------------------------------------
module sd_spi_command_sector_engine_unit
  import sdspi_pkg::*;
#(
  parameter int unsigned WakeBytes = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] block_address_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        cs_active_o,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o,
  output logic        want_write_data_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [7:0]  r1_response_o,
  output logic        high_capacity_o
);

  logic [7:0] retry_limit_q;
  logic       q_full, push, q_nempty, pop;
  item_t      push_item, pop_item;
  result_t    res;

  assign cfg_ready_o = 1'b1;

  // hold the retry limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= 8'hFF;
    end else if (cfg_valid_i) begin
      retry_limit_q <= cfg_data_i;
    end
  end

  sdspi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .operation_i,
    .cmd_index_i, .block_address_i, .rx_byte_i, .write_data_i,
    .q_full_i(q_full), .push_o(push), .push_item_o(push_item)
  );

  sdspi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_item_i(push_item), .full_o(q_full),
    .pop_i(pop), .nempty_o(q_nempty), .pop_item_o(pop_item)
  );

  sdspi_back #(.WakeBytes(WakeBytes)) u_back (
    .clk_i, .rst_ni, .retry_limit_i(retry_limit_q), .q_nempty_i(q_nempty),
    .q_item_i(pop_item), .pop_o(pop), .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign tx_valid_o        = res.tx_valid;
  assign tx_byte_o         = res.tx_byte;
  assign cs_active_o       = res.cs_active;
  assign read_valid_o      = res.read_valid;
  assign read_data_o       = res.read_data;
  assign want_write_data_o = res.want_write_data;
  assign done_res_o        = res.done_res;
  assign status_o          = res.status;
  assign r1_response_o     = res.r1_response;
  assign high_capacity_o   = res.high_capacity;

endmodule

// ===== rtl/sdspi_queue.sv =====
// ----------------------------------------------------------------------------
// sdspi_queue
// Two-entry word queue between the front and the back.
// ----------------------------------------------------------------------------
module sdspi_queue
  import sdspi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  nempty_o,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign nempty_o   = cnt_q != 2'd0;
  assign pop_item_o = mem_q[rp_q];

  // store incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_item_i;
    end
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/sdspi_front.sv =====
// ----------------------------------------------------------------------------
// sdspi_front
// Input stage: registers the incoming word, drops kind 3, queues the rest.
// ----------------------------------------------------------------------------
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] block_address_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  write_data_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       push_item_o
);

  logic  hold_q;
  item_t item_q;

  assign in_stall_o  = hold_q && q_full_i;
  assign push_o      = hold_q && !q_full_i;
  assign push_item_o = item_q;

  // capture word; drop codes with no meaning
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (!in_stall_o) begin
      hold_q <= in_valid_i && (kind_i != KIND_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      item_q <= '{kind: kind_e'(kind_i), operation: operation_i,
                  cmd_index: cmd_index_i, block_address: block_address_i,
                  rx_byte: rx_byte_i, write_data: write_data_i};
    end
  end

endmodule

// ===== rtl/sdspi_back.sv =====
// ----------------------------------------------------------------------------
// sdspi_back
// Sequencer: runs the wake, command, read and write phases, one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module sdspi_back
  import sdspi_pkg::*;
#(
  parameter int unsigned WakeBytes = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] retry_limit_i,
  input  logic       q_nempty_i,
  input  item_t      q_item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [7:0]  cret_q, cret_d, pret_q, pret_d, last_q, last_d;
  logic        baddr_q, baddr_d, v2_q, v2_d;
  logic [5:0]  ccmd_q, ccmd_d;
  logic [31:0] carg_q, carg_d;
  logic [1:0]  cop_q, cop_d;
  logic        ovld_q;
  result_t     res_q, res_d;
  logic        emit;

  logic        can_take;
  logic [31:0] sarg;
  logic [7:0]  fbyte;
  logic [2:0]  fidx;
  logic [7:0]  rx;
  logic [7:0]  r;

  assign can_take    = !ovld_q || !out_stall_i;
  assign pop_o       = q_nempty_i && can_take;
  assign out_valid_o = ovld_q;
  assign res_o       = res_q;
  assign rx          = q_item_i.rx_byte;

  // framing of the current command (uses next-state values)
  always_comb begin
    sarg = carg_d;
    if (!baddr_d && (ccmd_d == 6'd17 || ccmd_d == 6'd18 || ccmd_d == 6'd24 ||
                     ccmd_d == 6'd25 || ccmd_d == 6'd32 || ccmd_d == 6'd33)) begin
      sarg = {carg_d[22:0], 9'd0};
    end
    unique case (fidx)
      3'd0:    fbyte = 8'h40 | {2'b00, ccmd_d};
      3'd1:    fbyte = sarg[31:24];
      3'd2:    fbyte = sarg[23:16];
      3'd3:    fbyte = sarg[15:8];
      3'd4:    fbyte = sarg[7:0];
      default: fbyte = (ccmd_d == 6'd8) ? 8'h87 : 8'h95;
    endcase
  end

  // next state and result
  always_comb begin
    logic       sendf;
    logic       fin;
    logic [2:0] fst;
    logic       cmdone;
    logic       bc;
    logic [5:0] bcmd;
    logic [31:0] barg;
    sendf  = 1'b0;
    fin    = 1'b0;
    fst    = ST_OK;
    cmdone = 1'b0;
    bc     = 1'b0;
    bcmd   = 6'd0;
    barg   = 32'd0;
    phase_d = phase_q; cnt_d = cnt_q; cret_d = cret_q; pret_d = pret_q;
    last_d = last_q; baddr_d = baddr_q; v2_d = v2_q; ccmd_d = ccmd_q;
    carg_d = carg_q; cop_d = cop_q;
    res_d  = '0;
    emit   = 1'b0;
    fidx   = 3'd0;
    r      = last_q;

    // helpers expressed as flags: send byte
    if (pop_o) begin
      unique case (q_item_i.kind)
        KIND_START: begin
          if (phase_q == PH_IDLE) begin
            emit   = 1'b1;
            cop_d  = q_item_i.operation;
            cret_d = 8'd0;
            unique case (op_e'(q_item_i.operation))
              OP_INIT: begin
                v2_d = 1'b1; cnt_d = 10'd0; phase_d = PH_WAKE;
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF;
              end
              OP_CMD:  begin bc = 1'b1; bcmd = q_item_i.cmd_index;
                             barg = q_item_i.block_address; end
              OP_READ: begin bc = 1'b1; bcmd = 6'd17;
                             barg = q_item_i.block_address; end
              default: begin bc = 1'b1; bcmd = 6'd24;
                             barg = q_item_i.block_address; end
            endcase
          end
        end
        KIND_WDATA: begin
          if (phase_q == PH_WR_WANT) begin
            emit = 1'b1; phase_d = PH_WR_DATA;
            res_d.tx_valid = 1'b1; res_d.tx_byte = q_item_i.write_data;
            res_d.cs_active = 1'b1;
          end
        end
        KIND_RX: begin
          emit = (phase_q != PH_IDLE) && (phase_q != PH_WR_WANT);
          unique case (phase_q)
            PH_WAKE: begin
              cnt_d = cnt_q + 10'd1;
              if (cnt_d < 10'(WakeBytes)) begin
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF;
              end else begin
                cret_d = 8'd0; bc = 1'b1; bcmd = 6'd0; barg = 32'd0;
              end
            end
            PH_CMD_SEND: begin
              cnt_d = cnt_q + 10'd1;
              if (cnt_d < 10'd6) begin
                fidx = cnt_d[2:0]; sendf = 1'b1;
              end else begin
                phase_d = PH_CMD_POLL; pret_d = 8'd0;
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end
            end
            PH_CMD_POLL: begin
              if (rx[7] && pret_q != retry_limit_i) begin
                pret_d = pret_q + 8'd1;
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end else begin
                last_d = rx;
                r = rx;
                if (ccmd_q == 6'd8 || (ccmd_q == 6'd58 && rx == 8'd0)) begin
                  phase_d = PH_CMD_TAIL; cnt_d = 10'd0;
                  res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
                end else begin
                  cmdone = 1'b1;
                end
              end
            end
            PH_CMD_TAIL: begin
              if (ccmd_q == 6'd58 && cnt_q == 10'd0) baddr_d = rx[6];
              cnt_d = cnt_q + 10'd1;
              if (cnt_d < 10'd4) begin
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end else begin
                cmdone = 1'b1;
              end
            end
            PH_RD_TOKEN: begin
              if (rx == TokenStart) begin
                phase_d = PH_RD_DATA; cnt_d = 10'd0;
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end else if (pret_q == retry_limit_i) begin
                fin = 1'b1; fst = ST_READ_TIMEOUT;
              end else begin
                pret_d = pret_q + 8'd1;
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end
            end
            PH_RD_DATA: begin
              cnt_d = cnt_q + 10'd1;
              if (cnt_d == 10'(SectorBytes)) begin
                phase_d = PH_RD_TAIL; cnt_d = 10'd0;
              end
              res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              res_d.read_valid = 1'b1; res_d.read_data = rx;
            end
            PH_RD_TAIL: begin
              cnt_d = cnt_q + 10'd1;
              if (cnt_d < 10'd3) begin
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            PH_WR_TOKEN: begin
              cnt_d = 10'd0; phase_d = PH_WR_WANT;
              res_d.cs_active = 1'b1; res_d.want_write_data = 1'b1;
            end
            PH_WR_DATA: begin
              cnt_d = cnt_q + 10'd1;
              if (cnt_d < 10'(SectorBytes)) begin
                phase_d = PH_WR_WANT;
                res_d.cs_active = 1'b1; res_d.want_write_data = 1'b1;
              end else begin
                phase_d = PH_WR_CRC; cnt_d = 10'd0;
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'h00; res_d.cs_active = 1'b1;
              end
            end
            PH_WR_CRC: begin
              cnt_d = cnt_q + 10'd1;
              res_d.tx_valid = 1'b1; res_d.cs_active = 1'b1;
              if (cnt_d < 10'd2) begin
                res_d.tx_byte = 8'h00;
              end else begin
                phase_d = PH_WR_RESP; res_d.tx_byte = 8'hFF;
              end
            end
            PH_WR_RESP: begin
              phase_d = (rx[4:0] != 5'h05) ? PH_WR_REJ : PH_WR_BUSY1;
              res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
            end
            PH_WR_REJ: begin
              fin = 1'b1; fst = ST_WR_REJECTED;
            end
            PH_WR_BUSY1: begin
              res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF;
              if (rx == 8'd0) begin
                res_d.cs_active = 1'b1;
              end else begin
                phase_d = PH_WR_GAP;
              end
            end
            PH_WR_GAP: begin
              phase_d = PH_WR_BUSY2;
              res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
            end
            PH_WR_BUSY2: begin
              if (rx == 8'd0) begin
                res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // command complete: choose the next step
    if (cmdone) begin
      unique case (op_e'(cop_q))
        OP_CMD: fin = 1'b1;
        OP_READ: begin
          if (r == 8'd0) begin
            phase_d = PH_RD_TOKEN; pret_d = 8'd0;
            res_d.tx_valid = 1'b1; res_d.tx_byte = 8'hFF; res_d.cs_active = 1'b1;
          end else if (cret_q == retry_limit_i) begin
            fin = 1'b1; fst = ST_READ_TIMEOUT;
          end else begin
            cret_d = cret_q + 8'd1; bc = 1'b1; bcmd = ccmd_q; barg = carg_q;
          end
        end
        OP_WRITE: begin
          if (r == 8'd0) begin
            phase_d = PH_WR_TOKEN;
            res_d.tx_valid = 1'b1; res_d.tx_byte = TokenStart; res_d.cs_active = 1'b1;
          end else if (cret_q == retry_limit_i) begin
            fin = 1'b1; fst = ST_WCMD_TIMEOUT;
          end else begin
            cret_d = cret_q + 8'd1; bc = 1'b1; bcmd = ccmd_q; barg = carg_q;
          end
        end
        default: begin
          priority if (ccmd_q == 6'd0) begin
            if (r == 8'd1) begin
              cret_d = 8'd0; bc = 1'b1; bcmd = 6'd8; barg = 32'h1AA;
            end else if (cret_q == retry_limit_i) begin
              fin = 1'b1; fst = ST_IDLE_TIMEOUT;
            end else begin
              cret_d = cret_q + 8'd1; bc = 1'b1; bcmd = 6'd0; barg = carg_q;
            end
          end else if (ccmd_q == 6'd8) begin
            if (r == 8'd1 || cret_q == retry_limit_i) begin
              if (r != 8'd1) v2_d = 1'b0;
              cret_d = 8'd0; bc = 1'b1; bcmd = 6'd55; barg = 32'd0;
            end else begin
              cret_d = cret_q + 8'd1; bc = 1'b1; bcmd = 6'd8; barg = 32'h1AA;
            end
          end else if (ccmd_q == 6'd55) begin
            bc = 1'b1; bcmd = 6'd41; barg = 32'h4000_0000;
          end else if (ccmd_q == 6'd41) begin
            if (r == 8'd0) begin
              cret_d = 8'd0; baddr_d = 1'b0;
              if (v2_q) begin bc = 1'b1; bcmd = 6'd58; barg = 32'd0; end
              else fin = 1'b1;
            end else if (cret_q == retry_limit_i) begin
              fin = 1'b1; fst = ST_OPCOND_TIME;
            end else begin
              cret_d = cret_q + 8'd1; bc = 1'b1; bcmd = 6'd55; barg = 32'd0;
            end
          end else begin
            if (ccmd_q == 6'd58 && r != 8'd0 && cret_q != retry_limit_i) begin
              cret_d = cret_q + 8'd1; bc = 1'b1; bcmd = 6'd58; barg = 32'd0;
            end else begin
              fin = 1'b1;
            end
          end
        end
      endcase
    end

    // launch a command frame
    if (bc) begin
      ccmd_d = bcmd; carg_d = barg; cnt_d = 10'd0; pret_d = 8'd0;
      phase_d = PH_CMD_SEND; fidx = 3'd0; sendf = 1'b1;
    end
    if (sendf) begin
      res_d.tx_valid = 1'b1; res_d.tx_byte = fbyte; res_d.cs_active = 1'b1;
    end
    if (fin) begin
      phase_d = PH_IDLE;
      res_d = '0;
      res_d.done_res = 1'b1; res_d.status = fst;
    end
    res_d.r1_response   = last_d;
    res_d.high_capacity = baddr_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; cnt_q <= '0; cret_q <= '0; pret_q <= '0;
      last_q <= 8'hFF; baddr_q <= 1'b0; v2_q <= 1'b1; ccmd_q <= '0;
      carg_q <= '0; cop_q <= '0; ovld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d; cnt_q <= cnt_d; cret_q <= cret_d; pret_q <= pret_d;
        last_q <= last_d; baddr_q <= baddr_d; v2_q <= v2_d; ccmd_q <= ccmd_d;
        carg_q <= carg_d; cop_q <= cop_d;
      end
      if (can_take) ovld_q <= pop_o && emit;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (can_take && pop_o && emit) res_q <= res_d;
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SD SPI-mode sector engine. Drives start, card
// byte and write-data words shaped like a well-behaved card (with a share
// of bad responses and noise), predicts every result word in lockstep and
// compares each output word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import sdspi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WakeCount   = 10;
  localparam int IdleLimit   = 3000;
  localparam int PhaseBudget = 100;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [7:0] cfg_data = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  item_t   in_word = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t got;

  sd_spi_command_sector_engine_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (in_word.kind),
    .operation_i      (in_word.operation),
    .cmd_index_i      (in_word.cmd_index),
    .block_address_i  (in_word.block_address),
    .rx_byte_i        (in_word.rx_byte),
    .write_data_i     (in_word.write_data),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .tx_valid_o       (got.tx_valid),
    .tx_byte_o        (got.tx_byte),
    .cs_active_o      (got.cs_active),
    .read_valid_o     (got.read_valid),
    .read_data_o      (got.read_data),
    .want_write_data_o(got.want_write_data),
    .done_res_o       (got.done_res),
    .status_o         (got.status),
    .r1_response_o    (got.r1_response),
    .high_capacity_o  (got.high_capacity)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // sequencer mirror
  // --------------------------------------------------------------------------
  logic [7:0]  m_retry_lim = 8'd255;
  phase_e      m_phase = PH_IDLE;
  int unsigned m_count = 0;
  logic [7:0]  m_cmd_retry = '0;
  logic [7:0]  m_poll_retry = '0;
  bit          m_block_addr = 1'b0;
  bit          m_v2 = 1'b1;
  logic [5:0]  m_cmd = '0;
  logic [31:0] m_arg = '0;
  op_e         m_op = OP_INIT;
  logic [7:0]  m_last_r1 = 8'hFF;

  result_t expected_words[$];
  int      mismatches = 0;
  int      words_in = 0;
  int      words_out = 0;
  int      status_seen[8];
  int      idle_cycles = 0;
  bit      quiet = 1'b1;
  int      hold_token = 0;

  function automatic result_t pack_res(bit txv, logic [7:0] tx, bit cs, bit rv,
                                       logic [7:0] rd, bit want, bit done,
                                       status_e st);
    result_t r;
    r.tx_valid        = txv;
    r.tx_byte         = tx;
    r.cs_active       = cs;
    r.read_valid      = rv;
    r.read_data       = rd;
    r.want_write_data = want;
    r.done_res        = done;
    r.status          = st;
    r.r1_response     = m_last_r1;
    r.high_capacity   = m_block_addr;
    return r;
  endfunction

  function automatic result_t tx_only(logic [7:0] b, bit cs);
    return pack_res(1'b1, b, cs, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK);
  endfunction

  function automatic result_t want_word();
    return pack_res(1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, ST_OK);
  endfunction

  function automatic logic [7:0] frame_byte(int unsigned i);
    logic [31:0] a;
    a = m_arg;
    if (!m_block_addr && (m_cmd == 17 || m_cmd == 18 || m_cmd == 24 ||
                          m_cmd == 25 || m_cmd == 32 || m_cmd == 33))
      a = a << 9;
    case (i)
      0: return 8'h40 | {2'b00, m_cmd};
      1: return a[31:24];
      2: return a[23:16];
      3: return a[15:8];
      4: return a[7:0];
      default: return (m_cmd == 6'd8) ? 8'h87 : 8'h95;
    endcase
  endfunction

  function automatic result_t issue_cmd(logic [5:0] c, logic [31:0] a);
    m_cmd        = c;
    m_arg        = a;
    m_count      = 0;
    m_poll_retry = '0;
    m_phase      = PH_CMD_SEND;
    return tx_only(frame_byte(0), 1'b1);
  endfunction

  function automatic result_t close_op(status_e st);
    m_phase = PH_IDLE;
    return pack_res(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, st);
  endfunction

  function automatic result_t retry_or_close(status_e st);
    if (m_cmd_retry == m_retry_lim) return close_op(st);
    m_cmd_retry++;
    return issue_cmd(m_cmd, m_arg);
  endfunction

  // decide what follows a complete R1 (and its trailing bytes)
  function automatic result_t after_response();
    logic [7:0] r;
    r = m_last_r1;
    case (m_op)
      OP_CMD: return close_op(ST_OK);
      OP_READ: begin
        if (r != 0) return retry_or_close(ST_READ_TIMEOUT);
        m_phase      = PH_RD_TOKEN;
        m_poll_retry = '0;
        return tx_only(8'hFF, 1'b1);
      end
      OP_WRITE: begin
        if (r != 0) return retry_or_close(ST_WCMD_TIMEOUT);
        m_phase = PH_WR_TOKEN;
        return tx_only(TokenStart, 1'b1);
      end
      default: begin
        case (m_cmd)
          6'd0: begin
            if (r != 1) return retry_or_close(ST_IDLE_TIMEOUT);
            m_cmd_retry = '0;
            return issue_cmd(6'd8, 32'h1AA);
          end
          6'd8: begin
            if (r == 1 || m_cmd_retry == m_retry_lim) begin
              if (r != 1) m_v2 = 1'b0;
              m_cmd_retry = '0;
              return issue_cmd(6'd55, 32'h0);
            end
            m_cmd_retry++;
            return issue_cmd(6'd8, 32'h1AA);
          end
          6'd55: return issue_cmd(6'd41, 32'h4000_0000);
          6'd41: begin
            if (r == 0) begin
              m_cmd_retry  = '0;
              m_block_addr = 1'b0;
              if (m_v2) return issue_cmd(6'd58, 32'h0);
              return close_op(ST_OK);
            end
            if (m_cmd_retry == m_retry_lim) return close_op(ST_OPCOND_TIME);
            m_cmd_retry++;
            return issue_cmd(6'd55, 32'h0);
          end
          default: begin
            if (m_cmd == 6'd58 && r != 0 && m_cmd_retry != m_retry_lim) begin
              m_cmd_retry++;
              return issue_cmd(6'd58, 32'h0);
            end
            return close_op(ST_OK);
          end
        endcase
      end
    endcase
  endfunction

  function automatic bit card_byte(logic [7:0] rx, output result_t r);
    r = '0;
    case (m_phase)
      PH_WAKE: begin
        m_count++;
        if (m_count < WakeCount) r = tx_only(8'hFF, 1'b0);
        else begin
          m_cmd_retry = '0;
          r = issue_cmd(6'd0, 32'h0);
        end
      end
      PH_CMD_SEND: begin
        m_count++;
        if (m_count < 6) r = tx_only(frame_byte(m_count), 1'b1);
        else begin
          m_phase      = PH_CMD_POLL;
          m_poll_retry = '0;
          r = tx_only(8'hFF, 1'b1);
        end
      end
      PH_CMD_POLL: begin
        if (rx[7] && m_poll_retry != m_retry_lim) begin
          m_poll_retry++;
          r = tx_only(8'hFF, 1'b1);
        end else begin
          m_last_r1 = rx;
          if (m_cmd == 6'd8 || (m_cmd == 6'd58 && rx == 0)) begin
            m_phase = PH_CMD_TAIL;
            m_count = 0;
            r = tx_only(8'hFF, 1'b1);
          end else r = after_response();
        end
      end
      PH_CMD_TAIL: begin
        // first OCR byte carries the capacity bit
        if (m_cmd == 6'd58 && m_count == 0) m_block_addr = rx[6];
        m_count++;
        if (m_count < 4) r = tx_only(8'hFF, 1'b1);
        else r = after_response();
      end
      PH_RD_TOKEN: begin
        if (rx == TokenStart) begin
          m_phase = PH_RD_DATA;
          m_count = 0;
          r = tx_only(8'hFF, 1'b1);
        end else if (m_poll_retry == m_retry_lim) r = close_op(ST_READ_TIMEOUT);
        else begin
          m_poll_retry++;
          r = tx_only(8'hFF, 1'b1);
        end
      end
      PH_RD_DATA: begin
        m_count++;
        if (m_count >= SectorBytes) begin
          m_phase = PH_RD_TAIL;
          m_count = 0;
        end
        r = pack_res(1'b1, 8'hFF, 1'b1, 1'b1, rx, 1'b0, 1'b0, ST_OK);
      end
      PH_RD_TAIL: begin
        m_count++;
        if (m_count < 3) r = tx_only(8'hFF, 1'b1);
        else r = close_op(ST_OK);
      end
      PH_WR_TOKEN: begin
        m_count = 0;
        m_phase = PH_WR_WANT;
        r = want_word();
      end
      PH_WR_DATA: begin
        m_count++;
        if (m_count < SectorBytes) begin
          m_phase = PH_WR_WANT;
          r = want_word();
        end else begin
          m_phase = PH_WR_CRC;
          m_count = 0;
          r = tx_only(8'h00, 1'b1);
        end
      end
      PH_WR_CRC: begin
        m_count++;
        if (m_count < 2) r = tx_only(8'h00, 1'b1);
        else begin
          m_phase = PH_WR_RESP;
          r = tx_only(8'hFF, 1'b1);
        end
      end
      PH_WR_RESP: begin
        m_phase = (rx[4:0] != 5'h05) ? PH_WR_REJ : PH_WR_BUSY1;
        r = tx_only(8'hFF, 1'b1);
      end
      PH_WR_REJ: r = close_op(ST_WR_REJECTED);
      PH_WR_BUSY1: begin
        if (rx == 0) r = tx_only(8'hFF, 1'b1);
        else begin
          m_phase = PH_WR_GAP;
          r = tx_only(8'hFF, 1'b0);
        end
      end
      PH_WR_GAP: begin
        m_phase = PH_WR_BUSY2;
        r = tx_only(8'hFF, 1'b1);
      end
      PH_WR_BUSY2: begin
        if (rx == 0) r = tx_only(8'hFF, 1'b1);
        else r = close_op(ST_OK);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // advance the mirror by one accepted word; return 1 if it yields a result
  function automatic bit predict_word(item_t w, output result_t r);
    r = '0;
    case (w.kind)
      KIND_START: begin
        if (m_phase != PH_IDLE) return 1'b0;
        m_op        = op_e'(w.operation);
        m_cmd_retry = '0;
        case (op_e'(w.operation))
          OP_INIT: begin
            m_v2    = 1'b1;
            m_count = 0;
            m_phase = PH_WAKE;
            r = tx_only(8'hFF, 1'b0);
          end
          OP_CMD:  r = issue_cmd(w.cmd_index, w.block_address);
          OP_READ: r = issue_cmd(6'd17, w.block_address);
          default: r = issue_cmd(6'd24, w.block_address);
        endcase
        return 1'b1;
      end
      KIND_RX: return card_byte(w.rx_byte, r);
      KIND_WDATA: begin
        if (m_phase != PH_WR_WANT) return 1'b0;
        m_phase = PH_WR_DATA;
        r = tx_only(w.write_data, 1'b1);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // card-like word generator, steered by the mirrored phase
  // --------------------------------------------------------------------------
  function automatic item_t next_word();
    item_t w;
    int    p;
    w.kind          = KIND_RX;
    w.operation     = 2'($urandom);
    w.cmd_index     = 6'($urandom);
    w.block_address = $urandom;
    w.rx_byte       = 8'($urandom);
    w.write_data    = 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 4) begin
      w.kind = kind_e'($urandom_range(0, 3));
      return w;
    end
    p = $urandom_range(0, 99);
    case (m_phase)
      PH_IDLE: begin
        w.kind = KIND_START;
        if (p < 10) w.block_address = 32'hFFFF_FFFF;
        else if (p < 20) w.block_address = 32'h0;
      end
      PH_CMD_POLL: begin
        if (p < 15) w.rx_byte = 8'h80 | 8'($urandom);
        else if (p < 25) w.rx_byte = 8'($urandom) & 8'h7F;
        else if (m_op == OP_INIT && (m_cmd == 6'd0 || m_cmd == 6'd8 || m_cmd == 6'd55))
          w.rx_byte = 8'h01;
        else w.rx_byte = 8'h00;
      end
      PH_RD_TOKEN: if (p >= 20) w.rx_byte = TokenStart;
      PH_WR_WANT:  w.kind = KIND_WDATA;
      PH_WR_RESP:  if (p >= 15) w.rx_byte = (8'($urandom) & 8'hE0) | 8'h05;
      PH_WR_BUSY1, PH_WR_BUSY2: if (p < 50) w.rx_byte = 8'h00;
      default: ;
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task automatic offer_word(item_t w, bit typed, result_t typed_res);
    result_t r;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    idle_cycles = 0;
    words_in++;
    if (predict_word(w, r)) expected_words.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_gap();
    int p;
    int n;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return;
    n = (p < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_retry_limit(logic [7:0] v);
    drain_results();
    repeat (6) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    m_retry_lim = v;
    idle_cycles = 0;
  endtask

  // --------------------------------------------------------------------------
  // output side: stall, hold off and compare
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int hold_seen = 0;

  always @(posedge clk_i) begin
    result_t e;
    int      p;
    if (rst_ni && out_valid && !out_stall) begin
      idle_cycles = 0;
      words_out++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        e = expected_words.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
        end
        if (got.done_res) status_seen[got.status]++;
      end
    end
    p = $urandom_range(0, 99);
    if (hold_token != hold_seen) begin
      hold_seen  = hold_token;
      stall_left = 200;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && p < 10) stall_left = $urandom_range(1, 3);
      else if (!quiet && p < 12) stall_left = $urandom_range(15, 40);
    end
  end

  // end the run when nothing moves
  always @(posedge clk_i) begin
    idle_cycles++;
    if (idle_cycles > IdleLimit) begin
      $display("timeout, %0d words still expected", expected_words.size());
      $display("sd_spi_command_sector_engine_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // directed words
  // --------------------------------------------------------------------------
  typedef struct {
    item_t   w;
    bit      typed;
    result_t res;
  } stim_row_t;

  function automatic item_t mk_word(kind_e k, op_e o, logic [5:0] c, logic [31:0] a,
                                    logic [7:0] rx, logic [7:0] wd);
    item_t w;
    w.kind = k; w.operation = o; w.cmd_index = c;
    w.block_address = a; w.rx_byte = rx; w.write_data = wd;
    return w;
  endfunction

  function automatic result_t mk_res(bit txv, logic [7:0] tx, bit cs, bit done,
                                     status_e st, logic [7:0] r1);
    result_t r;
    r = '0;
    r.tx_valid = txv; r.tx_byte = tx; r.cs_active = cs;
    r.done_res = done; r.status = st; r.r1_response = r1;
    return r;
  endfunction

  stim_row_t directed_rows[$];

  initial begin
    logic [7:0] settings[5];
    int         budget;
    settings = '{8'd0, 8'd3, 8'd255, 8'd1, 8'($urandom)};

    // single command with all-ones fields, its frame bytes, then a ready R1
    directed_rows.push_back('{mk_word(KIND_START, OP_CMD, 6'd63, 32'hFFFF_FFFF, 0, 0), 1,
                              mk_res(1, 8'h7F, 1, 0, ST_OK, 8'hFF)});
    foreach (settings[i])
      directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'hFF, 0), 0, '0});
    directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'hFF, 0), 0, '0});
    directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'h00, 0), 1,
                              mk_res(0, 8'h00, 0, 1, ST_OK, 8'h00)});
    // ignored words: unused kind, unrequested write data, stray card byte
    directed_rows.push_back('{mk_word(KIND_NONE, OP_WRITE, 6'd63, 32'hFFFF_FFFF,
                                      8'hFF, 8'hFF), 0, '0});
    directed_rows.push_back('{mk_word(KIND_WDATA, OP_INIT, 0, 0, 0, 8'hA5), 0, '0});
    directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'h5A, 0), 0, '0});
    // CMD8 uses its own CRC and reads four trailing bytes; start while busy
    directed_rows.push_back('{mk_word(KIND_START, OP_CMD, 6'd8, 32'h0, 0, 0), 1,
                              mk_res(1, 8'h48, 1, 0, ST_OK, 8'h00)});
    directed_rows.push_back('{mk_word(KIND_START, OP_READ, 0, 32'h1, 0, 0), 0, '0});
    for (int i = 0; i < 6; i++)
      directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'hFF, 0), 0, '0});
    directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'h01, 0), 0, '0});
    for (int i = 0; i < 3; i++)
      directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'($urandom), 0), 0, '0});
    directed_rows.push_back('{mk_word(KIND_RX, OP_INIT, 0, 0, 8'hAA, 0), 1,
                              mk_res(0, 8'h00, 0, 1, ST_OK, 8'h01)});

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);

    // random phases, one retry limit each
    foreach (settings[s]) begin
      write_retry_limit(settings[s]);
      quiet  = (s == 3);
      budget = 0;
      if (s == 2) hold_token++;
      while (budget < PhaseBudget || m_phase != PH_IDLE) begin
        offer_word(next_word(), 1'b0, '0);
        budget++;
        // pause once mid-phase until the output side has caught up
        if (s == 1 && budget == PhaseBudget / 2) drain_results();
        idle_gap();
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("%0d words in, %0d words out, %0d retry settings", words_in, words_out,
             $size(settings));
    $display("completions ok/idle/opcond/read/wcmd/reject: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("sd_spi_command_sector_engine_unit regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sd_spi_command_sector_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
